/* sv/lif_pkg.sv */
// Package for the leaky integrate-and-fire neuron array.
// Holds sizes, register indexes, clamp limits and the per-channel state type.
// Depends on nothing; every other file of the block imports it.
package lif_pkg;

    localparam int CHANNELS = 64;
    localparam int CH_W     = 6;
    localparam int ADDR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SAMPLE_W = 16;
    localparam int MEM_W    = 24;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LEAK_FACTOR    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRE_THRESHOLD = 4'd1;

    // Register reset values and clamps.
    localparam logic [CFG_W-1:0] LEAK_RESET   = 16'd58982;
    localparam logic [CFG_W-1:0] THRESH_RESET = 16'd256;
    localparam logic [CFG_W-1:0] ALPHA_MAX    = 16'd65529;

    // Saturation limits of the membrane, at the width of the update sum.
    localparam int SUM_W = 27;
    localparam logic signed [SUM_W-1:0] MEM_MAX = 27'sd8388607;
    localparam logic signed [SUM_W-1:0] MEM_MIN = -27'sd8388608;

    // Rounding offset for the Q16.24 leak product.
    localparam logic signed [41:0] LEAK_ROUND = 42'sd32768;

    // State of one neuron channel as stored in the memory.
    typedef struct packed {
        logic                    spike;
        logic signed [MEM_W-1:0] membrane;
    } t_nrn_state;

endpackage

/* sv/lif_core.sv */
// Membrane update of one neuron for one time step: leak, integrate, soft
// reset, saturate and threshold compare. Pure combinational logic.
// Depends on lif_pkg.
module lif_core (
    input  logic signed [lif_pkg::SAMPLE_W-1:0] i_sample,
    input  lif_pkg::t_nrn_state                 i_old,
    input  logic [lif_pkg::CFG_W-1:0]           i_alpha,
    input  logic [lif_pkg::CFG_W-1:0]           i_thresh,
    output lif_pkg::t_nrn_state                 o_new
);
    import lif_pkg::*;

    logic signed [40:0]      prod;
    logic signed [41:0]      rnd;
    logic signed [25:0]      leaked;
    logic signed [16:0]      th_s;
    logic signed [SUM_W-1:0] sum;
    logic signed [MEM_W-1:0] v_sat;

    assign th_s = $signed({1'b0, i_thresh});
    assign prod = 41'(i_old.membrane) * 41'($signed({1'b0, i_alpha}));
    // Round to nearest with ties upward, then floor by an arithmetic shift.
    assign rnd    = 42'(prod) + LEAK_ROUND;
    assign leaked = $signed(rnd[41:16]);
    assign sum    = 27'(leaked) + 27'(i_sample) - (i_old.spike ? 27'(th_s) : 27'sd0);

    always_comb begin
        if (sum > MEM_MAX) begin
            v_sat = MEM_MAX[MEM_W-1:0];
        end else if (sum < MEM_MIN) begin
            v_sat = MEM_MIN[MEM_W-1:0];
        end else begin
            v_sat = sum[MEM_W-1:0];
        end
    end

    assign o_new.membrane = v_sat;
    assign o_new.spike    = (v_sat >= 24'(th_s));

endmodule

/* sv/lif_neuron_array_unit.sv */
// Top level of the leaky integrate-and-fire neuron array.
// Holds the configuration registers, the channel state memory and the
// two-stage pipeline around lif_core. Depends on lif_pkg and lif_core.
//
// Usage:
// The input channel carries one beat per neuron time step: a signed Q8.8
// sample, the channel index and a first-step flag that makes the channel
// start from a zero membrane and no previous spike. A beat is taken at a
// clock edge where i_in_valid is high and o_in_stall is low. Every input
// beat produces exactly one output beat carrying the spike bit and the
// channel index, taken where o_out_valid is high and i_out_stall is low.
// o_out_valid rises once the beat has passed the compute stage and has been
// loaded into the output register, which waits while the output stalls.
// Throughput is one beat per cycle while the receiver does not stall; it is
// set by the state memory, which has one read and one write per cycle: it is
// read as a beat is taken and written as the beat leaves the compute stage,
// with a bypass so a channel may repeat on consecutive beats.
// When the receiver stalls, the output register holds its beat, the one
// beat in the compute stage waits, and o_in_stall rises once both are full.
// The configuration channel (index, data) is always ready; write it only
// while the block is idle. Clamping of alpha and the threshold is applied
// when a register is written.
// Synchronous active-low reset restores the register defaults and clears
// the per-channel valid bits, so every channel reads as zero state at once;
// no clearing pass is needed.
module lif_neuron_array_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [lif_pkg::SAMPLE_W-1:0]  i_sample_value,
    input  logic [lif_pkg::CH_W-1:0]             i_channel,
    input  logic                                 i_first_step,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_spike,
    output logic [lif_pkg::CH_W-1:0]             o_out_channel,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lif_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lif_pkg::CFG_W-1:0]            i_cfg_data
);
    import lif_pkg::*;

    // Configuration registers, stored already clamped.
    logic [CFG_W-1:0] r_alpha;
    logic [CFG_W-1:0] r_thresh;

    // Channel state memory and its valid bits.
    t_nrn_state mem [CHANNELS];
    logic [CHANNELS-1:0] r_vld;

    // Compute stage.
    logic                       r_s1_valid;
    logic signed [SAMPLE_W-1:0] r_s1_sample;
    logic [CH_W-1:0]            r_s1_ch;
    logic                       r_s1_first;
    t_nrn_state                 r_rd;
    logic                       r_rd_vld;

    // Output register.
    logic            r_o_valid;
    logic            r_o_spike;
    logic [CH_W-1:0] r_o_ch;

    logic            out_ready;
    logic            s1_ready;
    logic            in_take;
    logic            s1_in_range;
    logic            wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic            bypass;
    t_nrn_state      old_state;
    t_nrn_state      new_state;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= LEAK_RESET;
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LEAK_FACTOR: begin
                    r_alpha <= (i_cfg_data > ALPHA_MAX) ? ALPHA_MAX : i_cfg_data;
                end
                REG_FIRE_THRESHOLD: begin
                    r_thresh <= (i_cfg_data == '0) ? CFG_W'(1) : i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Handshake: the output register frees when empty or taken; the compute
    // stage moves on whenever the output register can load.
    assign out_ready  = !r_o_valid || !i_out_stall;
    assign s1_ready   = !r_s1_valid || out_ready;
    assign o_in_stall = !s1_ready;
    assign in_take    = i_in_valid && s1_ready;

    assign s1_in_range = (32'(r_s1_ch) < CHANNELS);
    assign wr_en       = r_s1_valid && out_ready && s1_in_range;
    assign wr_addr     = ADDR_W'(r_s1_ch);
    assign rd_addr     = ADDR_W'(i_channel);
    // A beat that repeats the channel being written this cycle takes the
    // new state directly instead of the stale memory word.
    assign bypass      = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= new_state;
        end
        if (in_take) begin
            r_rd <= bypass ? new_state : mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_sample <= i_sample_value;
            r_s1_ch     <= i_channel;
            r_s1_first  <= i_first_step;
            r_rd_vld    <= bypass || r_vld[rd_addr];
        end
    end

    // A first step, or a channel never written since reset, starts from zero.
    always_comb begin
        if (r_s1_first || !r_rd_vld) begin
            old_state = '0;
        end else begin
            old_state = r_rd;
        end
    end

    lif_core u_core (
        .i_sample (r_s1_sample),
        .i_old    (old_state),
        .i_alpha  (r_alpha),
        .i_thresh (r_thresh),
        .o_new    (new_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_ready) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_s1_valid) begin
            r_o_spike <= s1_in_range && new_state.spike;
            r_o_ch    <= r_s1_ch;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_spike       = r_o_spike;
    assign o_out_channel = r_o_ch;

endmodule

/* sv/lif_checker.sv */
// Port-level checker for the neuron array and the bind that attaches it.
// Depends on lif_pkg and lif_neuron_array_unit.
module lif_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic                          o_spike,
    input logic [lif_pkg::CH_W-1:0]      o_out_channel,
    input logic                          o_cfg_ready
);
    import lif_pkg::*;

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Input back-pressure only arises from a full, stalled output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output back-pressure");

    // A stalled output beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_spike) && $stable(o_out_channel)))
        else $error("stalled output beat changed");

    // The configuration port never back-pressures.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind lif_neuron_array_unit lif_checker u_lif_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_spike       (o_spike),
    .o_out_channel (o_out_channel),
    .o_cfg_ready   (o_cfg_ready)
);
